[hw/rtl/prrq_pkg.sv]
// prrq_pkg: shared constants, opcodes, status codes and types for the run queue block
// no dependencies
package prrq_pkg;
  localparam int MAX_THREADS_D = 64;
  localparam int MAX_CORES_D   = 4;

  localparam logic [1:0] OP_ENQ       = 2'd0;
  localparam logic [1:0] OP_FIRST_ENQ = 2'd1;
  localparam logic [1:0] OP_YIELD     = 2'd2;
  localparam logic [1:0] OP_SET_RUN   = 2'd3;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_QUEUED = 2'd1;
  localparam logic [1:0] ST_NONE   = 2'd2;

  localparam logic CFG_NUM_CORES = 1'b0;
  localparam logic CFG_MULTICORE = 1'b1;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] thread_id;
    logic [1:0] core_id;
    logic       runnable;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic       switched;
    logic [5:0] run_thread;
    logic [1:0] assigned_core;
    logic [6:0] queue_length;
    logic [6:0] thread_count;
  } out_word_t;
endpackage

[hw/rtl/prrq_if.sv]
// prrq_if: valid/ready channel carrying one word
// depends on prrq_pkg for nothing but is generic over the word type
interface prrq_if #(parameter type word_t = logic) ();
  logic  valid;
  logic  ready;
  word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/prrq_ram.sv]
// prrq_ram: one-port-write, one-port-read synchronous memory, registered read
// no package dependency
module prrq_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/per_core_round_robin_run_queue_core.sv]
// per_core_round_robin_run_queue_core: top level, sequencer over the thread and queue memories
// depends on prrq_pkg, prrq_if, prrq_ram
//
// Usage: one word on in_ (opcode, thread, core, runnable) gives one word on out_.
// Config writes via cfg_we/cfg_index/cfg_data while idle: index 0 core count,
// index 1 multicore enable.
// Thread state (runnable, queued, core) lives in a thread table memory; queue
// entries in a run queue memory; per-core pointers, counts and current threads
// are in flops.
// Steps per word: set runnable reads the thread entry and writes it back;
// enqueue reads it, picks the core, writes it and the queue entry; yield pops
// entries until a runnable one is found, then read-modify-writes the core's
// current thread entry if any and the found thread entry. One word is in flight
// at a time; the registered memory reads of both memories set the steps.
// The result sits in an output register; the next word is taken once the
// result is taken, so a stalled receiver holds the block with the result
// steady. Reset empties all queues, clears marks and counts, no current
// threads, next round robin core 1. The run queue memory is not cleared;
// only written entries are ever read.
module per_core_round_robin_run_queue_core
  import prrq_pkg::*;
#(
  parameter int MAX_THREADS = MAX_THREADS_D,
  parameter int MAX_CORES   = MAX_CORES_D
) (
  input  logic       clk,
  input  logic       rst_n,
  prrq_if.sink       in_ch,
  prrq_if.source     out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [2:0] cfg_data
);
  localparam int TW = $clog2(MAX_THREADS);
  localparam int CW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
  localparam int NW = $clog2(MAX_THREADS + 1);
  localparam int AW = $clog2(MAX_CORES * MAX_THREADS);
  localparam int EW = 2 + CW; // runnable, queued, core
  localparam int RW = 2 * CW + 2;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TRD   = 4'd1; // thread entry read back
  localparam logic [3:0] S_ENQ   = 4'd2;
  localparam logic [3:0] S_POPRD = 4'd3; // queue entry read issued
  localparam logic [3:0] S_POPT  = 4'd4; // queue entry ready, read thread
  localparam logic [3:0] S_POPCK = 4'd5; // thread entry ready
  localparam logic [3:0] S_CURRD = 4'd6;
  localparam logic [3:0] S_CURCK = 4'd7;
  localparam logic [3:0] S_FOUND = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10; // found thread entry ready

  logic [3:0]  state_r;
  in_word_t    req_r;
  out_word_t   res_r;
  logic [2:0]  num_cores_r;
  logic        multi_r;
  logic [CW-1:0] next_core_r;
  logic [TW-1:0] head_r [MAX_CORES];
  logic [TW-1:0] tail_r [MAX_CORES];
  logic [NW-1:0] fill_r [MAX_CORES];
  logic [NW-1:0] cnt_r  [MAX_CORES];
  logic [TW-1:0] cur_r  [MAX_CORES];
  logic          curv_r [MAX_CORES];
  logic [MAX_THREADS-1:0] tvalid_r; // thread table entry written since reset
  logic [TW-1:0] nx_r;
  logic [CW-1:0] c_r;

  // thread number modulo the thread count
  function automatic logic [TW-1:0] tmod(input logic [5:0] v);
    logic [15:0] r;
    r = 16'(v);
    for (int k = 5; k >= 0; k--) begin
      if (r >= 16'(MAX_THREADS << k)) r = r - 16'(MAX_THREADS << k);
    end
    tmod = TW'(r);
  endfunction

  // queue pointer advance with wrap
  function automatic logic [TW-1:0] wrap_inc(input logic [TW-1:0] v);
    wrap_inc = (32'(v) == MAX_THREADS - 1) ? '0 : v + TW'(1);
  endfunction

  // thread table memory
  logic          t_we;
  logic [TW-1:0] t_waddr, t_raddr, t_rsel_r;
  logic [EW-1:0] t_wdata, t_rraw;
  logic [EW-1:0] t_rd;
  prrq_ram #(.WIDTH(EW), .DEPTH(MAX_THREADS)) u_thr (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rraw));
  assign t_rd = tvalid_r[t_rsel_r] ? t_rraw : '0;
  logic          rd_run, rd_q;
  logic [CW-1:0] rd_core;
  assign rd_run  = t_rd[EW-1];
  assign rd_q    = t_rd[EW-2];
  assign rd_core = t_rd[CW-1:0];

  // run queue memory
  logic          q_we;
  logic [AW-1:0] q_waddr, q_raddr;
  logic [TW-1:0] q_wdata, q_rd;
  prrq_ram #(.WIDTH(TW), .DEPTH(MAX_CORES * MAX_THREADS)) u_rq (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rd));

  logic [CW-1:0] ycore;
  assign ycore = CW'(req_r.core_id);
  logic yc_bad;
  assign yc_bad = (32'(req_r.core_id) >= MAX_CORES);
  logic [TW-1:0] tid;
  assign tid = tmod(req_r.thread_id);

  // effective core count and round robin pick
  logic [CW:0] eff;
  always_comb begin
    if (num_cores_r == 3'd0) eff = (CW+1)'(1);
    else if (32'(num_cores_r) > MAX_CORES) eff = (CW+1)'(MAX_CORES);
    else eff = (CW+1)'(num_cores_r);
  end
  logic [CW:0] nc_inc;
  assign nc_inc = {1'b0, next_core_r} + (CW+1)'(1);

  // next round robin core: remainder by shifted compare and subtract
  logic [RW-1:0] rr_rem;
  logic [CW:0]   nc_mod;
  always_comb begin
    rr_rem = RW'(nc_inc);
    for (int k = CW; k >= 0; k--) begin
      if (rr_rem >= (RW'(eff) << k)) rr_rem = rr_rem - (RW'(eff) << k);
    end
    nc_mod = rr_rem[CW:0];
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data  = res_r;

  function automatic logic [6:0] ext7(input logic [NW-1:0] v);
    ext7 = 7'(v);
  endfunction

  logic [TW-1:0] cur_t;
  assign cur_t = cur_r[ycore];

  always_comb begin
    t_we = 1'b0; t_waddr = tid; t_wdata = '0; t_raddr = tid;
    q_we = 1'b0; q_waddr = '0; q_wdata = tid; q_raddr = '0;
    case (state_r)
      S_IDLE:  t_raddr = tmod(in_ch.data.thread_id);
      S_TRD: begin
        if (req_r.opcode == OP_SET_RUN) begin
          t_we = 1'b1; t_wdata = {req_r.runnable, rd_q, rd_core};
        end
      end
      S_ENQ: begin
        t_we = 1'b1;
        t_wdata = {rd_run, rd_q, c_r};
        if (!rd_q && fill_r[c_r] < NW'(MAX_THREADS)) begin
          t_wdata = {rd_run, 1'b1, c_r};
          q_we = 1'b1;
          q_waddr = AW'(c_r * MAX_THREADS) + AW'(tail_r[c_r]);
        end
      end
      S_POPRD: q_raddr = AW'(ycore * MAX_THREADS) + AW'(head_r[ycore]);
      S_POPT:  t_raddr = q_rd;
      S_CURRD: t_raddr = cur_t;
      S_CURCK: begin
        t_waddr = cur_t; t_we = 1'b1;
        if (rd_run && !rd_q && fill_r[ycore] < NW'(MAX_THREADS)) begin
          t_wdata = {rd_run, 1'b1, rd_core};
          q_we = 1'b1; q_wdata = cur_t;
          q_waddr = AW'(ycore * MAX_THREADS) + AW'(tail_r[ycore]);
        end else if (rd_run && !rd_q) begin
          t_wdata = t_rd;
        end else begin
          t_wdata = {rd_run, 1'b0, rd_core};
        end
      end
      S_FOUND: t_raddr = nx_r;
      // found thread: write back with queued mark cleared
      S_FIN: begin
        t_waddr = nx_r; t_we = 1'b1;
        t_wdata = {rd_run, 1'b0, rd_core};
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      num_cores_r <= 3'd1; multi_r <= 1'b0;
      next_core_r <= CW'(1 % MAX_CORES);
      tvalid_r <= '0;
      for (int i = 0; i < MAX_CORES; i++) begin
        head_r[i] <= '0; tail_r[i] <= '0; fill_r[i] <= '0;
        cnt_r[i] <= '0; cur_r[i] <= '0; curv_r[i] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_NUM_CORES) num_cores_r <= cfg_data;
        else multi_r <= cfg_data[0];
      end
      if (t_we) tvalid_r[t_waddr] <= 1'b1;
      t_rsel_r <= t_raddr;
      case (state_r)
        S_IDLE: if (in_ch.valid) begin
          req_r <= in_ch.data;
          state_r <= (in_ch.data.opcode == OP_YIELD) ? S_POPRD : S_TRD;
        end
        S_TRD: begin
          if (req_r.opcode == OP_SET_RUN) begin
            res_r <= '{ST_DONE, 1'b0, 6'd0, 2'(rd_core), ext7(fill_r[rd_core]),
                       ext7(cnt_r[rd_core])};
            state_r <= S_OUT;
          end else begin
            if (req_r.opcode == OP_FIRST_ENQ && multi_r) begin
              c_r <= ({1'b0, next_core_r} < eff) ? next_core_r : '0;
              next_core_r <= CW'(nc_mod);
            end else begin
              c_r <= rd_core;
            end
            state_r <= S_ENQ;
          end
        end
        S_ENQ: begin
          logic [NW-1:0] cn, fl;
          cn = (cnt_r[c_r] < NW'(MAX_THREADS)) ? cnt_r[c_r] + NW'(1) : cnt_r[c_r];
          fl = fill_r[c_r];
          cnt_r[c_r] <= cn;
          if (q_we) begin
            fl = fl + NW'(1);
            fill_r[c_r] <= fl;
            tail_r[c_r] <= wrap_inc(tail_r[c_r]);
          end
          res_r <= '{rd_q ? ST_QUEUED : ST_DONE, 1'b0, 6'd0, 2'(c_r), ext7(fl), ext7(cn)};
          state_r <= S_OUT;
        end
        S_POPRD: begin
          if (yc_bad) begin
            res_r <= '{ST_NONE, 1'b0, 6'd0, req_r.core_id, 7'd0, 7'd0};
            state_r <= S_OUT;
          end else if (fill_r[ycore] == '0) begin
            res_r <= '{ST_NONE, 1'b0, curv_r[ycore] ? 6'(cur_t) : 6'd0, req_r.core_id,
                       ext7(fill_r[ycore]), ext7(cnt_r[ycore])};
            state_r <= S_OUT;
          end else begin
            head_r[ycore] <= wrap_inc(head_r[ycore]);
            fill_r[ycore] <= fill_r[ycore] - NW'(1);
            state_r <= S_POPT;
          end
        end
        S_POPT: begin nx_r <= q_rd; state_r <= S_POPCK; end
        S_POPCK: state_r <= rd_run ? (curv_r[ycore] ? S_CURRD : S_FOUND) : S_POPRD;
        S_CURRD: state_r <= S_CURCK;
        S_CURCK: begin
          if (rd_run && !rd_q) begin
            if (q_we) begin
              tail_r[ycore] <= wrap_inc(tail_r[ycore]);
              fill_r[ycore] <= fill_r[ycore] + NW'(1);
            end
          end else if (cnt_r[rd_core] != '0) begin
            cnt_r[rd_core] <= cnt_r[rd_core] - NW'(1);
          end
          state_r <= S_FOUND;
        end
        S_FOUND: state_r <= S_FIN;
        // found thread becomes current, then finish
        S_FIN: begin
          cur_r[ycore] <= nx_r; curv_r[ycore] <= 1'b1;
          res_r <= '{ST_DONE, 1'b1, 6'(nx_r), req_r.core_id,
                     ext7(fill_r[ycore]), ext7(cnt_r[ycore])};
          state_r <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready) else $error("accepted while busy");
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[0] <= NW'(MAX_THREADS)) else $error("queue overfilled");
  a_switch_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.switched) |-> out_ch.data.status == ST_DONE)
    else $error("switch with bad status");
`endif
endmodule
